[rtl/bitmap_page_frame_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// bitmap page frame allocator assertion macros
// shared property forms for the port checker; expects clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define BPFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// shared widths, codes and types of the bitmap page frame allocator
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int FRAME_W     = 20;
    localparam int COUNT_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [FRAME_W-1:0] RAM_BASE_FRAME_RESET = 20'h90000;
    localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET     = 16'h8000;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RAM_BASE_FRAME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGE_COUNT     = 2'd1;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_MEMORY    = 2'd1,
        STATUS_OUT_OF_RANGE = 2'd2,
        STATUS_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_RESP
    } state_t;

endpackage

[rtl/bpfa_ram.sv]
// ----------------------------------------------------------------------------
// bpfa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/bpfa_word_search.sv]
// ----------------------------------------------------------------------------
// bpfa_word_search
// finds the lowest free page bit of one bitmap word inside a bit window
// ----------------------------------------------------------------------------
module bpfa_word_search #(
    parameter int WORD_BITS = 64,
    parameter int LO_W      = $clog2(WORD_BITS),
    parameter int AV_W      = $clog2(WORD_BITS + 1)
) (
    input  logic [WORD_BITS-1:0] occ,
    input  logic [LO_W-1:0]      lo,
    input  logic [AV_W-1:0]      avail,
    output logic                 found,
    output logic [LO_W-1:0]      pos
);

    logic [WORD_BITS-1:0] cand;

    // free, at or above the start bit, below the page count
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            cand[b] = !occ[b] && (LO_W'(b) >= lo) && (AV_W'(b) < avail);
        end
    end

    // priority pick, lowest bit wins
    always_comb
    begin
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                pos = LO_W'(b);
            end
        end
    end

    assign found = |cand;

endmodule

[rtl/bitmap_page_frame_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// next-fit physical page frame allocator over an occupancy bitmap in ram
// ----------------------------------------------------------------------------
// One word in, one word out. An allocate scans the bitmap ram one word per
// cycle, starting at the word that holds the search pointer, and reads 1 up
// to NUM_PAGES / WORD_BITS words through that ram's single read port before
// its result is loaded. A free reads the word, clears the bit if it is set,
// then loads the result; a request that fails before touching the ram (free
// outside the range, allocate with the pointer at or past the page count)
// goes straight to the result. One request is worked at a time; the next is
// taken while the last result still sits in the output register. After
// reset a clearing pass writes zero to all NUM_PAGES / WORD_BITS bitmap
// words, one per cycle, with in_ready low; configuration writes are taken
// throughout. WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_unit #(
    parameter int NUM_PAGES = 32768,
    parameter int WORD_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [bpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [bpfa_pkg::FRAME_W-1:0]     frame_number,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bpfa_pkg::FRAME_W-1:0]     result_frame,
    output logic [bpfa_pkg::STATUS_W-1:0]    status
);

    import bpfa_pkg::*;

    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int AVW       = $clog2(WORD_BITS + 1);
    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    // page index width, wide enough to hold NUM_PAGES itself
    localparam int PW        = $clog2(NUM_PAGES + 1);
    // working width for index compares against frame offsets
    localparam int IW        = (PW > FRAME_W) ? PW : FRAME_W;

    // control state
    state_t               state_reg, state_next;
    logic [FRAME_W-1:0]   base_reg;
    logic [COUNT_W-1:0]   page_count_reg;
    logic [PW-1:0]        search_start_reg, search_start_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;

    // payload
    logic [AW-1:0]        scan_word_reg, scan_word_next;
    logic [WB_LOG-1:0]    scan_lo_reg, scan_lo_next;
    logic [PW-1:0]        free_idx_reg, free_idx_next;
    logic [FRAME_W-1:0]   res_frame_reg, res_frame_next;
    status_t              res_status_reg, res_status_next;
    logic [FRAME_W-1:0]   out_frame_reg, out_frame_next;
    status_t              out_status_reg, out_status_next;

    // bitmap ram ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    // datapath
    logic                 in_accept;
    logic                 out_load;
    logic [IW-1:0]        count_eff;
    logic [IW-1:0]        start_idx;
    logic                 start_oom;
    logic [FRAME_W-1:0]   free_offset;
    logic                 free_oor;
    logic [IW-1:0]        base_idx;
    logic [IW-1:0]        rem_pages;
    logic [AVW-1:0]       avail;
    logic                 found;
    logic [WB_LOG-1:0]    pos;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        next_base;
    logic                 scan_end;
    logic [WB_LOG-1:0]    free_bit;
    logic                 free_used;

    // ------------------------------------------------------------------
    // bitmap storage and the per-word free bit finder
    // ------------------------------------------------------------------
    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bpfa_word_search #(
        .WORD_BITS (WORD_BITS)
    ) u_search (
        .occ   (rd_data),
        .lo    (scan_lo_reg),
        .avail (avail),
        .found (found),
        .pos   (pos)
    );

    // ------------------------------------------------------------------
    // shared decode
    // ------------------------------------------------------------------
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == ST_RESP) && (!out_valid_reg || out_ready);

    // page count clamps at the built capacity
    assign count_eff = (IW'(page_count_reg) > IW'(NUM_PAGES)) ? IW'(NUM_PAGES)
                                                              : IW'(page_count_reg);

    // allocate fails at once when the pointer already sits at or past the count
    assign start_idx = IW'(search_start_reg);
    assign start_oom = (start_idx >= count_eff);

    // frame offset wraps modulo the frame space
    assign free_offset = frame_number - base_reg;
    assign free_oor    = (IW'(free_offset) >= count_eff);

    // scan window of the word now on the ram read data
    assign base_idx  = IW'(scan_word_reg) << WB_LOG;
    assign rem_pages = count_eff - base_idx;
    assign avail     = (rem_pages >= IW'(WORD_BITS)) ? AVW'(WORD_BITS) : AVW'(rem_pages);
    assign hit_idx   = base_idx + IW'(pos);
    assign next_base = base_idx + IW'(WORD_BITS);
    assign scan_end  = (next_base >= count_eff);

    assign free_bit  = free_idx_reg[WB_LOG-1:0];
    assign free_used = rd_data[free_bit];

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (operation == OP_FREE)
                    begin
                        state_next = free_oor ? ST_RESP : ST_FREE;
                    end
                    else
                    begin
                        state_next = start_oom ? ST_RESP : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found || scan_end)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and ram control
    // ------------------------------------------------------------------
    always_comb
    begin
        search_start_next = search_start_reg;
        clr_next          = clr_reg;
        scan_word_next    = scan_word_reg;
        scan_lo_next      = scan_lo_reg;
        free_idx_next     = free_idx_reg;
        res_frame_next    = res_frame_reg;
        res_status_next   = res_status_reg;
        wr_en             = 1'b0;
        wr_addr           = scan_word_reg;
        wr_data           = rd_data;
        // during a scan, fetch the following word ahead
        rd_addr           = scan_word_reg + AW'(1);

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (operation == OP_FREE)
                begin
                    rd_addr = AW'(IW'(free_offset) >> WB_LOG);
                end
                else
                begin
                    rd_addr = AW'(start_idx >> WB_LOG);
                end
                if (in_accept)
                begin
                    if (operation == OP_FREE)
                    begin
                        free_idx_next   = PW'(free_offset);
                        res_frame_next  = frame_number;
                        res_status_next = free_oor ? STATUS_OUT_OF_RANGE : STATUS_OK;
                    end
                    else
                    begin
                        scan_word_next  = AW'(start_idx >> WB_LOG);
                        scan_lo_next    = search_start_reg[WB_LOG-1:0];
                        res_frame_next  = '0;
                        res_status_next = STATUS_NO_MEMORY;
                    end
                end
            end
            ST_SCAN:
            begin
                if (found)
                begin
                    // mark the page used and move the pointer past it
                    wr_en             = 1'b1;
                    wr_addr           = scan_word_reg;
                    wr_data           = rd_data | (WORD_BITS'(1) << pos);
                    search_start_next = PW'(hit_idx + IW'(1));
                    res_frame_next    = base_reg + FRAME_W'(hit_idx);
                    res_status_next   = STATUS_OK;
                end
                else
                begin
                    scan_word_next = scan_word_reg + AW'(1);
                    scan_lo_next   = '0;
                end
            end
            ST_FREE:
            begin
                if (free_used)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(free_idx_reg >> WB_LOG);
                    wr_data = rd_data & ~(WORD_BITS'(1) << free_bit);
                    // next-fit pointer falls back to a lower freed page
                    if (free_idx_reg < search_start_reg)
                    begin
                        search_start_next = free_idx_reg;
                    end
                end
                else
                begin
                    res_status_next = STATUS_ALREADY_FREE;
                end
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register, refilled as soon as the old word has left
    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ready;
        out_frame_next  = out_frame_reg;
        out_status_next = out_status_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_frame_next  = res_frame_reg;
            out_status_next = res_status_reg;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            search_start_reg <= '0;
            clr_reg          <= '0;
            out_valid_reg    <= 1'b0;
            base_reg         <= RAM_BASE_FRAME_RESET;
            page_count_reg   <= PAGE_COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            search_start_reg <= search_start_next;
            clr_reg          <= clr_next;
            out_valid_reg    <= out_valid_next;
            // writes to unknown indexes fall through
            if (cfg_write && (cfg_index == REG_RAM_BASE_FRAME))
            begin
                base_reg <= cfg_data[FRAME_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_PAGE_COUNT))
            begin
                page_count_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_word_reg  <= scan_word_next;
        scan_lo_reg    <= scan_lo_next;
        free_idx_reg   <= free_idx_next;
        res_frame_reg  <= res_frame_next;
        res_status_reg <= res_status_next;
        out_frame_reg  <= out_frame_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_frame = out_frame_reg;
    assign status       = out_status_reg;

endmodule

[rtl/bpfa_checker.sv]
// ----------------------------------------------------------------------------
// bpfa_checker
// port level checks of the page frame allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "bitmap_page_frame_allocator_unit_assert.svh"

module bpfa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          operation,
    input logic [bpfa_pkg::FRAME_W-1:0]  frame_number,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [bpfa_pkg::FRAME_W-1:0]  result_frame,
    input logic [bpfa_pkg::STATUS_W-1:0] status
);

    import bpfa_pkg::*;

    logic [1:0]         cnt_reg, cnt_next;
    logic               last_op_reg;
    logic [FRAME_W-1:0] last_frame_reg;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // words accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg + (in_acc ? 2'd1 : 2'd0) - (out_acc ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            last_op_reg    <= OP_ALLOC;
            last_frame_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                last_op_reg    <= operation;
                last_frame_reg <= frame_number;
            end
        end
    end

    `BPFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_frame) && $stable(status), "result word changed while stalled")

    `BPFA_ASSERT_NOW(a_no_extra_result, out_valid, cnt_reg != 2'd0,
        "result word without a request")

    `BPFA_ASSERT_NOW(a_one_in_flight, in_ready, cnt_reg != 2'd2,
        "request taken with two words outstanding")

    `BPFA_ASSERT_NOW(a_free_echo, out_valid && (cnt_reg == 2'd1) && (last_op_reg == OP_FREE),
        result_frame == last_frame_reg, "free result does not echo its frame")

    `BPFA_ASSERT_NOW(a_alloc_status,
        out_valid && (cnt_reg == 2'd1) && (last_op_reg == OP_ALLOC),
        (status == STATUS_OK) || ((status == STATUS_NO_MEMORY) && (result_frame == '0)),
        "bad allocate result")

endmodule

bind bitmap_page_frame_allocator_unit bpfa_checker u_bpfa_checker (.*);
